// ----- hw/rtl/sap_pkg.sv -----
// Shared types and constants for the shelf atlas packer.
// No dependencies; compiled first.
package sap_pkg;

    localparam int MAX_PAGES = 8;
    localparam int PU_W      = $clog2(MAX_PAGES + 1);  // holds 0..MAX_PAGES
    localparam int DIM_W     = 16;
    localparam int PAD_W     = 8;
    localparam int PAGE_W    = 3;
    localparam int CFG_IDX_W = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_PIXELS   = 2'd2;

    localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 16'd1024;
    localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 16'd1024;
    localparam logic [PAD_W-1:0] PAD_PIXELS_RST   = 8'd1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PAD_W-1:0] pad;
    } t_cfg;

    // request token walking the cell chain (padded sizes, already known to fit a page)
    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] pw;
        logic [DIM_W-1:0] ph;
    } t_tok;

    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] pos_x;
        logic [DIM_W-1:0] pos_y;
    } t_hit;

endpackage

// ----- hw/rtl/sap_if.sv -----
// Handshake channels of the shelf atlas packer: request, result, config write.
// Depends on sap_pkg.
interface sap_req_if;
    import sap_pkg::*;
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] rect_w;
    logic [DIM_W-1:0] rect_h;
    modport source (output valid, rect_w, rect_h, input ready);
    modport sink   (input valid, rect_w, rect_h, output ready);
endinterface

interface sap_res_if;
    import sap_pkg::*;
    logic              valid;
    logic              ready;
    logic              placed;
    logic [PAGE_W-1:0] page_id;
    logic [DIM_W-1:0]  pos_x;
    logic [DIM_W-1:0]  pos_y;
    logic [DIM_W-1:0]  out_w;
    logic [DIM_W-1:0]  out_h;
    modport source (output valid, placed, page_id, pos_x, pos_y, out_w, out_h,
                    input ready);
    modport sink   (input valid, placed, page_id, pos_x, pos_y, out_w, out_h,
                    output ready);
endinterface

interface sap_cfg_if;
    import sap_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sap_cell.sv -----
// One page of the atlas: shelf cursor state plus the token stage to the next page.
// Depends on sap_pkg.
module sap_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sap_pkg::t_cfg i_cfg,
    input  sap_pkg::t_tok i_tok,
    input  logic          i_in_use,
    input  logic          i_append,
    output sap_pkg::t_tok o_tok,
    output sap_pkg::t_hit o_hit
);
    import sap_pkg::*;

    logic [DIM_W-1:0] r_cx, r_sy, r_sh;
    logic [DIM_W-1:0] n_cx, n_sy, n_sh;
    t_tok             r_tok, n_tok;

    logic [DIM_W-1:0] b_cx, b_sy, b_sh;
    logic [DIM_W:0]   ny;
    logic [DIM_W-1:0] cx1, sy1, sh1;
    logic             active, new_shelf, fit;

    always_comb begin
        // an appended page starts cleared
        b_cx = i_append ? '0 : r_cx;
        b_sy = i_append ? '0 : r_sy;
        b_sh = i_append ? '0 : r_sh;

        active    = i_tok.valid && (i_in_use || i_append);
        new_shelf = ({1'b0, b_cx} + {1'b0, i_tok.pw}) > {1'b0, i_cfg.width};
        ny        = {1'b0, b_sy} + {1'b0, b_sh};

        cx1 = new_shelf ? '0 : b_cx;
        sy1 = new_shelf ? (ny[DIM_W] ? '1 : ny[DIM_W-1:0]) : b_sy;
        sh1 = new_shelf ? '0 : b_sh;

        fit = ({1'b0, sy1} + {1'b0, i_tok.ph}) <= {1'b0, i_cfg.height};

        n_cx = r_cx;
        n_sy = r_sy;
        n_sh = r_sh;
        if (active) begin
            n_sy = sy1;
            if (fit) begin
                n_cx = cx1 + i_tok.pw;
                n_sh = (i_tok.ph > sh1) ? i_tok.ph : sh1;
            end else begin
                n_cx = cx1;
                n_sh = sh1;
            end
        end

        o_hit.valid = active && fit;
        o_hit.pos_x = cx1 + {{(DIM_W-PAD_W){1'b0}}, i_cfg.pad};
        o_hit.pos_y = sy1 + {{(DIM_W-PAD_W){1'b0}}, i_cfg.pad};

        n_tok       = i_tok;
        n_tok.valid = i_tok.valid && !(active && fit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_sy  <= '0;
            r_sh  <= '0;
            r_tok <= '0;
        end else begin
            r_cx  <= n_cx;
            r_sy  <= n_sy;
            r_sh  <= n_sh;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- hw/rtl/shelf_atlas_packer.sv -----
// Shelf atlas packer: a request placed on page k passes the inject register, the token
// registers of the pages before page k, the result holding stage and the output register;
// an oversized request goes straight to the result holding stage, and a full walk that
// fails is reported once the token leaves the last page. One request is in the page chain
// at a time; a new one is taken once the chain and the result holding stage are free.
// Reset (synchronous, active low) clears all pages, sets one page in use and loads
// the default page size and padding; no clearing pass is needed.
// Depends on sap_pkg, sap_if, sap_cell.
module shelf_atlas_packer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sap_cfg_if.sink   i_cfg,
    sap_req_if.sink   i_req,
    sap_res_if.source o_res
);
    import sap_pkg::*;

    // ---- configuration registers, always writable
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= ATLAS_WIDTH_RST;
            r_cfg.height <= ATLAS_HEIGHT_RST;
            r_cfg.pad    <= PAD_PIXELS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ATLAS_WIDTH:  r_cfg.width  <= i_cfg.data;
                CFG_ATLAS_HEIGHT: r_cfg.height <= i_cfg.data;
                CFG_PAD_PIXELS:   r_cfg.pad    <= i_cfg.data[PAD_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---- request front end: pad, size check, inject token into page 0
    logic             req_fire, too_large;
    logic [DIM_W:0]   pw, ph, pad2;

    logic             r_busy;       // a token is walking the chain
    logic             r_inj_v;
    logic [DIM_W-1:0] r_inj_pw, r_inj_ph;
    logic [DIM_W-1:0] r_w, r_h;     // echo of the request being placed

    // result holding stage, then output register
    logic              r_res_v;
    logic              r_res_placed;
    logic [PAGE_W-1:0] r_res_page;
    logic [DIM_W-1:0]  r_res_x, r_res_y;

    assign i_req.ready = !r_busy && !r_res_v;
    assign req_fire    = i_req.valid && i_req.ready;

    // padded sizes keep the 17th bit so they cannot wrap
    assign pad2      = {{(DIM_W-PAD_W){1'b0}}, r_cfg.pad, 1'b0};
    assign pw        = {1'b0, i_req.rect_w} + pad2;
    assign ph        = {1'b0, i_req.rect_h} + pad2;
    assign too_large = (pw > {1'b0, r_cfg.width}) || (ph > {1'b0, r_cfg.height});

    // ---- the page chain
    t_tok            w_tok [MAX_PAGES+1];
    t_hit            w_hit [MAX_PAGES];
    logic [MAX_PAGES-1:0] w_in_use, w_append;
    logic [PU_W-1:0] r_pages_used;

    assign w_tok[0] = '{valid: r_inj_v, pw: r_inj_pw, ph: r_inj_ph};

    for (genvar k = 0; k < MAX_PAGES; k++) begin : g_page
        assign w_in_use[k] = PU_W'(k) < r_pages_used;
        assign w_append[k] = PU_W'(k) == r_pages_used;

        sap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (r_cfg),
            .i_tok    (w_tok[k]),
            .i_in_use (w_in_use[k]),
            .i_append (w_append[k]),
            .o_tok    (w_tok[k+1]),
            .o_hit    (w_hit[k])
        );
    end

    // at most one cell hits per cycle; a token leaving the last page is a failure
    logic              any_hit, grow, walk_fail;
    logic [PAGE_W-1:0] hit_page;
    logic [DIM_W-1:0]  hit_x, hit_y;

    always_comb begin
        any_hit  = 1'b0;
        grow     = 1'b0;
        hit_page = '0;
        hit_x    = '0;
        hit_y    = '0;
        for (int k = 0; k < MAX_PAGES; k++) begin
            if (w_hit[k].valid) begin
                any_hit  = 1'b1;
                grow     = w_append[k];
                hit_page = PAGE_W'(k);
                hit_x    = w_hit[k].pos_x;
                hit_y    = w_hit[k].pos_y;
            end
        end
        walk_fail = w_tok[MAX_PAGES].valid;
    end

    logic out_load;
    assign out_load = r_res_v && (!o_res.valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_inj_v      <= 1'b0;
            r_res_v      <= 1'b0;
            r_pages_used <= PU_W'(1);
        end else begin
            // token lives in the inject stage for one cycle only
            r_inj_v <= req_fire && !too_large;
            if (grow) begin
                r_pages_used <= r_pages_used + PU_W'(1);
            end
            if (req_fire) begin
                if (too_large) begin
                    r_res_v <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (any_hit || walk_fail) begin
                r_busy  <= 1'b0;
                r_res_v <= 1'b1;
            end else if (out_load) begin
                r_res_v <= 1'b0;
            end
        end
    end

    // payload of the front end and result stage
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_inj_pw     <= pw[DIM_W-1:0];
            r_inj_ph     <= ph[DIM_W-1:0];
            r_w          <= i_req.rect_w;
            r_h          <= i_req.rect_h;
            r_res_placed <= 1'b0;
        end else if (any_hit || walk_fail) begin
            r_res_placed <= any_hit;
            r_res_page   <= hit_page;
            r_res_x      <= hit_x;
            r_res_y      <= hit_y;
        end
    end

    // ---- output register: the chain may take the next request while a beat waits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (out_load) begin
            o_res.valid <= 1'b1;
        end else if (o_res.ready) begin
            o_res.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_res.placed  <= r_res_placed;
            o_res.page_id <= r_res_placed ? r_res_page : '0;
            o_res.pos_x   <= r_res_placed ? r_res_x : '0;
            o_res.pos_y   <= r_res_placed ? r_res_y : '0;
            o_res.out_w   <= r_res_placed ? r_w : '0;
            o_res.out_h   <= r_res_placed ? r_h : '0;
        end
    end

endmodule

// ----- hw/rtl/sap_checker.sv -----
// Port-level checks for the shelf atlas packer, bound to the top level.
// Depends on sap_pkg and shelf_atlas_packer.
module sap_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_placed,
    input logic [sap_pkg::PAGE_W-1:0] i_page_id,
    input logic [sap_pkg::DIM_W-1:0]  i_pos_x,
    input logic [sap_pkg::DIM_W-1:0]  i_pos_y,
    input logic [sap_pkg::DIM_W-1:0]  i_out_w,
    input logic [sap_pkg::DIM_W-1:0]  i_out_h
);
    import sap_pkg::*;

    logic       in_fire, out_fire;
    logic [1:0] r_open;   // requests taken whose result beat is not yet taken

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, in_fire} - {1'b0, out_fire};
        end
    end

    // a failed placement carries an all-zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_placed |->
            i_page_id == '0 && i_pos_x == '0 && i_pos_y == '0 &&
            i_out_w == '0 && i_out_h == '0)
        else $error("failed result with nonzero payload");

    // no result beat without a request behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 2'd0)
        else $error("result beat with no open request");

    // at most one request in the chain plus one waiting result
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> r_open != 2'd2)
        else $error("request taken with two results outstanding");

    // a stalled result beat stays valid and keeps its placed flag, page and position
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_placed) && $stable(i_page_id) &&
            $stable(i_pos_x) && $stable(i_pos_y))
        else $error("stalled result beat changed");

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_placed     (o_res.placed),
    .i_page_id    (o_res.page_id),
    .i_pos_x      (o_res.pos_x),
    .i_pos_y      (o_res.pos_y),
    .i_out_w      (o_res.out_w),
    .i_out_h      (o_res.out_h)
);
